FILE: sv/fla_pkg.sv
// Shared types and constants for the free-list slot allocator.
`timescale 1ns / 1ps

package fla_pkg;

    localparam int SLOTS  = 256;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int LINK_W = IDX_W + 1;

    localparam int POOL_W   = 9;
    localparam int BASE_W   = 64;
    localparam int STRIDE_W = 12;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W   = IDX_W + STRIDE_W;

    // A link or head value with the top bit set means the list ends here.
    localparam logic [LINK_W-1:0] LIST_EMPTY = LINK_W'(SLOTS);
    localparam logic [POOL_W-1:0] POOL_MAX   = POOL_W'(SLOTS);

    localparam logic [POOL_W-1:0]   POOL_RESET   = 9'd256;
    localparam logic [BASE_W-1:0]   BASE_RESET   = 64'd0;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 12'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HANDLE_BASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HANDLE_STRIDE = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_BAD_INDEX = 2'd2
    } status_t;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] slot_index;
    } cmd_t;

    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  granted_index;
        logic [BASE_W-1:0] handle_address;
    } result_t;

    // Decision handed from the list control to the result stage.
    typedef struct packed {
        logic             valid;
        status_t          status;
        logic [IDX_W-1:0] index;
    } grant_t;

endpackage

FILE: sv/fla_link_mem.sv
// Link memory: one next-slot entry per slot, one write and one registered read port.
`timescale 1ns / 1ps

module fla_link_mem (
    input  logic                      clk,
    input  logic                      we,
    input  logic [fla_pkg::IDX_W-1:0] waddr,
    input  logic [fla_pkg::LINK_W-1:0] wdata,
    input  logic                      rd_en,
    input  logic [fla_pkg::IDX_W-1:0] raddr,
    output logic [fla_pkg::LINK_W-1:0] rdata
);
    import fla_pkg::*;

    logic [LINK_W-1:0] mem [SLOTS];
    logic [LINK_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/fla_list_ctrl.sv
// Free-list head, fresh-slot watermark and the allocate/free decision.
`timescale 1ns / 1ps

module fla_list_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  fla_pkg::cmd_t                 cmd,
    input  logic [fla_pkg::POOL_W-1:0]    pool_size,
    output fla_pkg::grant_t               grant
);
    import fla_pkg::*;

    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] head_link_reg, head_link_next;
    logic              pending_reg, pending_next;
    logic [POOL_W-1:0] fresh_reg, fresh_next;

    logic [LINK_W-1:0] head_link_cur;
    logic [POOL_W-1:0] size;
    logic              mem_we;
    logic              mem_rd_en;
    logic [LINK_W-1:0] mem_rdata;

    // After a pop the link of the new head arrives from memory in the next cycle.
    assign head_link_cur = pending_reg ? mem_rdata : head_link_reg;
    assign size = (pool_size > POOL_MAX) ? POOL_MAX : pool_size;

    always_comb
    begin
        head_next      = head_reg;
        head_link_next = head_link_cur;
        fresh_next     = fresh_reg;
        mem_we         = 1'b0;
        mem_rd_en      = 1'b0;
        grant.valid    = accept;
        grant.status   = STATUS_OK;
        grant.index    = '0;
        if (accept)
        begin
            if (cmd.kind == KIND_ALLOC)
            begin
                if (!head_reg[LINK_W-1])
                begin
                    grant.index = head_reg[IDX_W-1:0];
                    head_next   = head_link_cur;
                    mem_rd_en   = !head_link_cur[LINK_W-1];
                end
                else if (fresh_reg < size)
                begin
                    grant.index = fresh_reg[IDX_W-1:0];
                    fresh_next  = fresh_reg + 1'b1;
                end
                else
                begin
                    grant.status = STATUS_EMPTY;
                end
            end
            else
            begin
                if ({1'b0, cmd.slot_index} >= size)
                begin
                    grant.status = STATUS_BAD_INDEX;
                end
                else
                begin
                    grant.index    = cmd.slot_index;
                    mem_we         = 1'b1;
                    head_next      = {1'b0, cmd.slot_index};
                    head_link_next = head_reg;
                end
            end
        end
        pending_next = mem_rd_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= LIST_EMPTY;
            head_link_reg <= LIST_EMPTY;
            pending_reg   <= 1'b0;
            fresh_reg     <= '0;
        end
        else
        begin
            head_reg      <= head_next;
            head_link_reg <= head_link_next;
            pending_reg   <= pending_next;
            fresh_reg     <= fresh_next;
        end
    end

    fla_link_mem u_link_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (cmd.slot_index),
        .wdata (head_reg),
        .rd_en (mem_rd_en),
        .raddr (head_link_cur[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

endmodule

FILE: sv/fla_result_reg.sv
// Handle address computation and the result register with its strobe.
`timescale 1ns / 1ps

module fla_result_reg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fla_pkg::grant_t              grant,
    input  logic [fla_pkg::BASE_W-1:0]   handle_base,
    input  logic [fla_pkg::STRIDE_W-1:0] handle_stride,
    output logic                         done,
    output fla_pkg::result_t             result
);
    import fla_pkg::*;

    logic [PROD_W-1:0] offset;
    result_t           result_next;
    result_t           result_reg;
    logic              done_reg;

    assign offset = PROD_W'(grant.index) * PROD_W'(handle_stride);

    always_comb
    begin
        result_next.status = grant.status;
        if (grant.status == STATUS_OK)
        begin
            result_next.granted_index  = grant.index;
            result_next.handle_address = handle_base + BASE_W'(offset);
        end
        else
        begin
            result_next.granted_index  = '0;
            result_next.handle_address = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= grant.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (grant.valid)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: sv/free_list_slot_allocator_top.sv
// Top level of the free-list slot allocator: configuration registers and wiring.
`timescale 1ns / 1ps
// A command accepted at one clock edge has its result on the result
// ports, with done high, for the single cycle that follows that edge.
// Throughput: one command per cycle; busy stays low, since the link of the new
// head is read from the link memory during a pop and is ready in the next cycle.
// Reset: the free list is empty, the fresh-slot watermark is zero and the
// registers take their defaults; the link memory is not cleared.

module free_list_slot_allocator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  fla_pkg::cmd_t                 cmd,
    output logic                          done,
    output fla_pkg::result_t              result,
    input  logic                          cfg_we,
    input  logic [fla_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fla_pkg::CFG_W-1:0]     cfg_data
);
    import fla_pkg::*;

    logic [POOL_W-1:0]   pool_size_reg;
    logic [BASE_W-1:0]   handle_base_reg;
    logic [STRIDE_W-1:0] handle_stride_reg;

    logic   accept;
    grant_t grant;

    // The block never needs to hold off a command: a pop that needs the next
    // link from memory has it registered before the following command is
    // decided, and a free gets the new head's link from the old head directly.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration writes land at once; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg     <= POOL_RESET;
            handle_base_reg   <= BASE_RESET;
            handle_stride_reg <= STRIDE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POOL_SIZE:     pool_size_reg     <= cfg_data[POOL_W-1:0];
                CFG_HANDLE_BASE:   handle_base_reg   <= cfg_data[BASE_W-1:0];
                CFG_HANDLE_STRIDE: handle_stride_reg <= cfg_data[STRIDE_W-1:0];
                default:           ;
            endcase
        end
    end

    // Decides the slot for each command and keeps the free list in order:
    // freed slots come back last in, first out, then untouched slots rise.
    fla_list_ctrl u_list_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (cmd),
        .pool_size (pool_size_reg),
        .grant     (grant)
    );

    // Turns the decision into the result beat with its handle address.
    fla_result_reg u_result_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .grant         (grant),
        .handle_base   (handle_base_reg),
        .handle_stride (handle_stride_reg),
        .done          (done),
        .result        (result)
    );

endmodule
